/* rtl/papt_pkg.sv */
`default_nettype none

package papt_pkg;

    localparam int NUM_SLOTS_DEF     = 16;
    localparam int TICKS_PER_SEC_DEF = 1000;

    // result kinds
    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_FULL   = 2'd2;

    // slot memory read address select
    localparam logic [1:0] RA_ZERO = 2'd0;
    localparam logic [1:0] RA_IDX  = 2'd1;
    localparam logic [1:0] RA_NEXT = 2'd2;
    localparam logic [1:0] RA_PREV = 2'd3;

    // index register operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_INC   = 3'd2;
    localparam logic [2:0] IDX_DEC   = 3'd3;
    localparam logic [2:0] IDX_COUNT = 3'd4;

    typedef struct packed {
        logic        func;
        logic [15:0] proc_id;
        logic [15:0] seconds;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] target_id;
        logic [15:0] remaining_sec;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [1:0] rd_addr;
        logic       wr_en;
        logic       wr_new;
        logic [2:0] idx_op;
        logic       pos_ld;
        logic       found_set;
        logic       div_start;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       exp_start;
        logic       out_ld;
        logic [1:0] out_kind;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic secs_zero;
        logic found;
        logic idx_eq_cnt;
        logic idx1_ge_cnt;
        logic idx_eq_pos;
        logic cnt_zero;
        logic cnt_full;
        logic owner_hit;
        logic due_now;
        logic ins_le;
        logic next_due;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/papt_div.sv */
`default_nettype none

module papt_div import papt_pkg::*; #(
    parameter int TICKS_PER_SEC = TICKS_PER_SEC_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    output logic             o_busy,
    output logic [31:0]      o_quot
);

    // x / d == (x * M) >> (32 + L) for every 32-bit x, with L = ceil(log2 d)
    // and M = floor(2^(32+L) / d) + 1, which fits in 33 bits
    localparam int          LW    = $clog2(TICKS_PER_SEC);
    localparam int          SH    = 32 + LW;
    localparam logic [63:0] RECIP = ((64'd1 << SH) / 64'(TICKS_PER_SEC)) + 64'd1;
    localparam logic [32:0] MUL   = RECIP[32:0];

    logic          r_busy, n_busy;
    logic          r_step, n_step;
    logic [31:0]   r_num, n_num;
    logic [65:0]   r_acc, n_acc;
    logic [15:0]   half;
    logic [48:0]   part;

    // one 16 x 33 partial product per cycle, low half of the dividend first
    assign half = r_step ? r_num[31:16] : r_num[15:0];
    assign part = 49'(half) * 49'(MUL);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_num  = r_num;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 1'b0;
            n_num  = i_dividend;
            n_acc  = '0;
        end else if (r_busy) begin
            n_step = 1'b1;
            if (r_step) begin
                n_acc  = r_acc + {1'b0, part, 16'd0};
                n_busy = 1'b0;
            end else begin
                n_acc = {17'd0, part};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_acc <= n_acc;
    end

    assign o_busy = r_busy;
    assign o_quot = 32'(r_acc >> SH);

endmodule

`default_nettype wire

/* rtl/papt_dpath.sv */
`default_nettype none

module papt_dpath import papt_pkg::*; #(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int TICKS_PER_SEC = TICKS_PER_SEC_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_stall,
    output t_stat          o_stat,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int TW = $clog2(TICKS_PER_SEC + 1);
    localparam int PW = 16 + TW;

    logic [31:0] mem_due   [NUM_SLOTS];
    logic [15:0] mem_owner [NUM_SLOTS];

    logic          r_func;
    logic [15:0]   r_pid;
    logic          r_secs_zero;
    logic [31:0]   r_delay;
    logic [31:0]   r_now;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos;
    logic          r_found;
    logic          r_next_due;
    logic [15:0]   r_hold;
    logic [31:0]   r_rd_due;
    logic [15:0]   r_rd_owner;
    logic          r_out_valid;
    t_out_item     r_out, n_out;

    logic [PW-1:0] prod;
    logic [63:0]   prod_wide;
    logic [31:0]   delay;
    logic [CW:0]   idx_p1;
    logic [CW-1:0] idx_m1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_due;
    logic [15:0]   wr_owner;
    logic          div_busy;
    logic [31:0]   div_quot;
    logic [15:0]   rem_sat;

    // delay in ms, clamped to 32 bits
    assign prod      = PW'(i_in_data.seconds) * PW'(TICKS_PER_SEC);
    assign prod_wide = 64'(prod);
    assign delay     = (|prod_wide[63:32]) ? 32'hFFFF_FFFF : prod_wide[31:0];

    assign idx_p1 = {1'b0, r_idx} + (CW + 1)'(1);
    assign idx_m1 = r_idx - CW'(1);

    always_comb begin
        unique case (i_cmd.rd_addr)
            RA_ZERO: rd_addr = '0;
            RA_IDX:  rd_addr = r_idx[AW-1:0];
            RA_NEXT: rd_addr = idx_p1[AW-1:0];
            RA_PREV: rd_addr = idx_m1[AW-1:0];
        endcase
    end

    assign wr_addr  = r_idx[AW-1:0];
    assign wr_due   = i_cmd.wr_new ? (r_now + r_delay) : r_rd_due;
    assign wr_owner = i_cmd.wr_new ? r_pid : r_rd_owner;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_due[wr_addr]   <= wr_due;
            mem_owner[wr_addr] <= wr_owner;
        end
        if (i_cmd.rd_en) begin
            r_rd_due   <= mem_due[rd_addr];
            r_rd_owner <= mem_owner[rd_addr];
        end
    end

    papt_div #(
        .TICKS_PER_SEC(TICKS_PER_SEC)
    ) u_papt_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd_due - r_now),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign rem_sat = (|div_quot[31:16]) ? 16'hFFFF : div_quot[15:0];

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = idx_p1[CW-1:0];
            IDX_DEC:   n_idx = idx_m1;
            IDX_COUNT: n_idx = r_cnt;
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        n_out.kind          = i_cmd.out_kind;
        n_out.target_id     = (i_cmd.out_kind == KIND_EXPIRE) ? r_hold : r_pid;
        n_out.remaining_sec = ((i_cmd.out_kind == KIND_REPLY) && r_found) ? rem_sat : 16'd0;
        n_out.last          = (i_cmd.out_kind == KIND_EXPIRE) ? !r_next_due : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_next_due  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.accept && i_in_data.func) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cmd.accept) begin
                r_found <= 1'b0;
            end else if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            // new head of the table after a shift decides whether more expire
            if (i_cmd.exp_start) begin
                r_next_due <= 1'b0;
            end else if (i_cmd.wr_en && !i_cmd.wr_new && (r_idx == '0)) begin
                r_next_due <= (r_rd_due == r_now);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func      <= i_in_data.func;
            r_pid       <= i_in_data.proc_id;
            r_secs_zero <= (i_in_data.seconds == 16'd0);
            r_delay     <= delay;
        end
        if (i_cmd.pos_ld) begin
            r_pos <= r_idx;
        end
        if (i_cmd.exp_start) begin
            r_hold <= r_rd_owner;
        end
        if (i_cmd.out_ld) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_stat.is_tick     = r_func;
        o_stat.secs_zero   = r_secs_zero;
        o_stat.found       = r_found;
        o_stat.idx_eq_cnt  = (r_idx == r_cnt);
        o_stat.idx1_ge_cnt = (idx_p1 >= {1'b0, r_cnt});
        o_stat.idx_eq_pos  = (r_idx == r_pos);
        o_stat.cnt_zero    = (r_cnt == '0);
        o_stat.cnt_full    = (r_cnt == CW'(NUM_SLOTS));
        o_stat.owner_hit   = (r_rd_owner == r_pid);
        o_stat.due_now     = (r_rd_due == r_now);
        o_stat.ins_le      = ((r_rd_due - r_now) <= r_delay);
        o_stat.next_due    = r_next_due;
        o_stat.div_busy    = div_busy;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/papt_ctrl.sv */
`default_nettype none

module papt_ctrl import papt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_func,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SRCH   = 4'd1;
    localparam logic [3:0] ST_SCMP   = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_RM     = 4'd4;
    localparam logic [3:0] ST_RMW    = 4'd5;
    localparam logic [3:0] ST_DEC    = 4'd6;
    localparam logic [3:0] ST_IFIND  = 4'd7;
    localparam logic [3:0] ST_ICMP   = 4'd8;
    localparam logic [3:0] ST_ISHIFT = 4'd9;
    localparam logic [3:0] ST_ISHW   = 4'd10;
    localparam logic [3:0] ST_REPLY  = 4'd11;
    localparam logic [3:0] ST_REFUSE = 4'd12;
    localparam logic [3:0] ST_TCHK   = 4'd13;
    localparam logic [3:0] ST_TCMP   = 4'd14;
    localparam logic [3:0] ST_TEMIT  = 4'd15;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.idx_op = IDX_ZERO;
                    n_state      = i_in_func ? ST_TCHK : ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (i_stat.idx_eq_cnt) begin
                    n_state = ST_DEC;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_IDX;
                    n_state       = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (i_stat.owner_hit) begin
                    o_cmd.found_set = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = ST_SRCH;
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_RM;
                end
            end
            ST_RM: begin
                if (i_stat.idx1_ge_cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = i_stat.is_tick ? ST_TEMIT : ST_DEC;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_NEXT;
                    n_state       = ST_RMW;
                end
            end
            ST_RMW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
                n_state      = ST_RM;
            end
            ST_DEC: begin
                if (i_stat.secs_zero) begin
                    n_state = ST_REPLY;
                end else if (!i_stat.found && i_stat.cnt_full) begin
                    n_state = ST_REFUSE;
                end else begin
                    o_cmd.idx_op = IDX_ZERO;
                    n_state      = ST_IFIND;
                end
            end
            ST_IFIND: begin
                if (i_stat.idx_eq_cnt) begin
                    o_cmd.pos_ld = 1'b1;
                    n_state      = ST_ISHIFT;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_IDX;
                    n_state       = ST_ICMP;
                end
            end
            ST_ICMP: begin
                if (i_stat.ins_le) begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = ST_IFIND;
                end else begin
                    o_cmd.pos_ld = 1'b1;
                    o_cmd.idx_op = IDX_COUNT;
                    n_state      = ST_ISHIFT;
                end
            end
            ST_ISHIFT: begin
                if (i_stat.idx_eq_pos) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = ST_REPLY;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_PREV;
                    n_state       = ST_ISHW;
                end
            end
            ST_ISHW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
                n_state      = ST_ISHIFT;
            end
            ST_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = KIND_REPLY;
                    n_state        = ST_IDLE;
                end
            end
            ST_REFUSE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = KIND_FULL;
                    n_state        = ST_IDLE;
                end
            end
            ST_TCHK: begin
                if (i_stat.cnt_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_ZERO;
                    n_state       = ST_TCMP;
                end
            end
            ST_TCMP: begin
                if (i_stat.due_now) begin
                    o_cmd.exp_start = 1'b1;
                    o_cmd.idx_op    = IDX_ZERO;
                    n_state         = ST_RM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = KIND_EXPIRE;
                    n_state        = i_stat.next_due ? ST_TCHK : ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/per_process_alarm_table.sv */
// per-process alarm table: one-shot alarms, at most one per process, sorted by due time
// input channel (i_in_valid / i_in_data / o_in_stall): func 0 sets or cancels the
//   alarm of proc_id, func 1 is a one millisecond tick
// output channel (o_out_valid / o_out_data / i_out_stall): set replies, refusals
//   when the table is full, and expired alarms in due order, last marks the final
//   result of an item
// one item is in work at a time; o_in_stall is high from the cycle after a transfer
//   until its last result is loaded into the output register, if it yields one
// set: a search of the armed slots for the old alarm of proc_id; if one is found, a
//   reciprocal multiply for its seconds left and a removal that shifts the later
//   slots down; unless seconds is zero or the table is full with no old alarm, a
//   search for the insertion point and a shift of the later slots up; then the reply
// tick: nothing on an empty table or when the head is not due; otherwise each due
//   alarm is taken from the head as the table shifts down and sent as an expiry
// the output register holds a result while i_out_stall is high and the controller
//   waits before loading the next one
// reset (synchronous, active low) clears the clock, the slot count and the state
//   machine; slot memory contents are left as they are and are never read unarmed
`default_nettype none

module per_process_alarm_table import papt_pkg::*; #(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int TICKS_PER_SEC = TICKS_PER_SEC_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    // command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    papt_ctrl u_papt_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_data.func),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // slot memory, clock, counters, divider and output register
    papt_dpath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .TICKS_PER_SEC (TICKS_PER_SEC)
    ) u_papt_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/papt_checker.sv */
`default_nettype none

module papt_checker import papt_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_data,
    input wire logic      i_out_stall
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    // replies and refusals are the only result of their item
    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.kind == KIND_REPLY) || (o_out_data.kind == KIND_FULL))
        |-> o_out_data.last)
        else $error("set reply not marked last");

    // seconds left only on a set reply
    a_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind != KIND_REPLY) |-> (o_out_data.remaining_sec == 16'd0))
        else $error("seconds left on a result other than a set reply");

endmodule

bind per_process_alarm_table papt_checker u_papt_checker (.*);

`default_nettype wire
